/* rtl/rhc_pkg.sv */
package rhc_pkg;

    localparam int CH_W  = 8;
    localparam int HUE_W = 15;

    // Hue quotient trunc(3840 * diff / delta) never exceeds 3840.
    localparam int HQ_W = 12;
    localparam int HN_W = 20;

    // Saturation quotient floor(delta * 255 / max) never exceeds 255.
    localparam int SQ_W = 8;
    localparam int SN_W = 16;

    localparam logic [HUE_W-1:0] HUE_FULL_TURN = HUE_W'(23040);
    localparam logic [HUE_W-1:0] RED_OFFSET    = HUE_W'(0);
    localparam logic [HUE_W-1:0] GREEN_OFFSET  = HUE_W'(7680);
    localparam logic [HUE_W-1:0] BLUE_OFFSET   = HUE_W'(15360);

    typedef struct packed {
        logic [HN_W-1:0]  hrem;
        logic [HQ_W-1:0]  hq;
        logic [CH_W-1:0]  hden;
        logic [SN_W-1:0]  srem;
        logic [SQ_W-1:0]  sq;
        logic [CH_W-1:0]  sden;
        logic             neg;
        logic [HUE_W-1:0] offset;
        logic [CH_W-1:0]  value;
    } div_item_t;

endpackage

/* rtl/rhc_div_pipe.sv */
module rhc_div_pipe
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rhc_pkg::div_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output rhc_pkg::div_item_t out_item
);

    localparam int NSTG = rhc_pkg::HQ_W;
    localparam int SOFF = rhc_pkg::HQ_W - rhc_pkg::SQ_W;

    rhc_pkg::div_item_t item_reg  [NSTG];
    rhc_pkg::div_item_t item_next [NSTG];
    rhc_pkg::div_item_t src       [NSTG];
    logic [NSTG-1:0]    valid_reg;
    logic [NSTG-1:0]    src_valid;
    logic [NSTG:0]      ready;

    assign ready[NSTG] = out_ready;
    assign in_ready    = ready[0];
    assign out_valid   = valid_reg[NSTG-1];
    assign out_item    = item_reg[NSTG-1];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stage
            localparam int HB = NSTG - 1 - k;
            localparam int SB = (k >= SOFF) ? (rhc_pkg::SQ_W - 1 - (k - SOFF)) : 0;

            logic [rhc_pkg::HN_W:0] hsub;
            logic [rhc_pkg::HN_W:0] hdiff;
            logic [rhc_pkg::SN_W:0] ssub;
            logic [rhc_pkg::SN_W:0] sdiff;

            if (k == 0)
            begin : g_first
                assign src[k]       = in_item;
                assign src_valid[k] = in_valid;
            end
            else
            begin : g_rest
                assign src[k]       = item_reg[k-1];
                assign src_valid[k] = valid_reg[k-1];
            end

            assign ready[k] = !valid_reg[k] || ready[k+1];
            assign hsub  = (rhc_pkg::HN_W + 1)'(src[k].hden) << HB;
            assign hdiff = {1'b0, src[k].hrem} - hsub;
            assign ssub  = (rhc_pkg::SN_W + 1)'(src[k].sden) << SB;
            assign sdiff = {1'b0, src[k].srem} - ssub;

            always_comb
            begin
                item_next[k] = src[k];
                if (!hdiff[rhc_pkg::HN_W])
                begin
                    item_next[k].hrem   = hdiff[rhc_pkg::HN_W-1:0];
                    item_next[k].hq[HB] = 1'b1;
                end
                if ((k >= SOFF) && !sdiff[rhc_pkg::SN_W])
                begin
                    item_next[k].srem   = sdiff[rhc_pkg::SN_W-1:0];
                    item_next[k].sq[SB] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (ready[k] && src_valid[k])
                begin
                    item_reg[k] <= item_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= src_valid[i];
                end
            end
        end
    end

endmodule

/* rtl/rgb_to_hsv_convert_core.sv */
// Channel   Direction  Signals                      Fields (lowest bit first)
// s_axis    in         s_tvalid s_tready s_tdata    red, green, blue
// m_axis    out        m_tvalid m_tready m_tdata    hue, saturation, brightness
//
// One pixel per cycle is taken in steady flow, unless m_tready stalls the output; each
// result passes two front stages, twelve divider stages and one output register,
// the first of them loaded at the transfer edge.
// The twelve-stage restoring divider for the hue quotient sets the latency.
// Reset clears only the valid bits of every stage; data registers are not reset.
// Each stage holds while its successor is full and stalled, so empty stages close
// up and no pixel is dropped or repeated.
module rgb_to_hsv_convert_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue [14:0], saturation [22:15], brightness [30:23]
);

    localparam int CW = rhc_pkg::CH_W;
    localparam int HW = rhc_pkg::HUE_W;

    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;

    assign red   = s_tdata[CW-1:0];
    assign green = s_tdata[2*CW-1:CW];
    assign blue  = s_tdata[3*CW-1:2*CW];

    // Stage A: channel extremes.
    logic          a_valid_reg;
    logic          a_ready;
    logic [CW-1:0] a_red_reg, a_green_reg, a_blue_reg, a_max_reg, a_min_reg;
    logic [CW-1:0] a_max_next, a_min_next;

    always_comb
    begin
        a_max_next = red;
        a_min_next = red;
        if (green > a_max_next)
        begin
            a_max_next = green;
        end
        if (blue > a_max_next)
        begin
            a_max_next = blue;
        end
        if (green < a_min_next)
        begin
            a_min_next = green;
        end
        if (blue < a_min_next)
        begin
            a_min_next = blue;
        end
    end

    // Stage B: sector choice and dividends.
    logic               b_valid_reg;
    logic               b_ready;
    rhc_pkg::div_item_t b_item_reg;
    rhc_pkg::div_item_t b_item_next;
    logic [CW-1:0]      delta;
    logic [CW-1:0]      opa, opb, diff;

    always_comb
    begin
        delta = a_max_reg - a_min_reg;
        if (a_max_reg == a_red_reg)
        begin
            opa = a_green_reg;
            opb = a_blue_reg;
            b_item_next.offset = rhc_pkg::RED_OFFSET;
        end
        else if (a_max_reg == a_green_reg)
        begin
            opa = a_blue_reg;
            opb = a_red_reg;
            b_item_next.offset = rhc_pkg::GREEN_OFFSET;
        end
        else
        begin
            opa = a_red_reg;
            opb = a_green_reg;
            b_item_next.offset = rhc_pkg::BLUE_OFFSET;
        end
        b_item_next.neg = (opa < opb);
        diff = (opa < opb) ? (opb - opa) : (opa - opb);

        // A grey pixel divides zero by one, which gives hue 0 with offset 0.
        if (delta == '0)
        begin
            b_item_next.offset = rhc_pkg::RED_OFFSET;
            b_item_next.neg    = 1'b0;
            b_item_next.hden   = CW'(1);
        end
        else
        begin
            b_item_next.hden = delta;
        end
        // 3840 * diff and 255 * delta as shifts and one subtraction each.
        b_item_next.hrem = (rhc_pkg::HN_W'(diff) << 12) - (rhc_pkg::HN_W'(diff) << 8);
        b_item_next.srem = (rhc_pkg::SN_W'(delta) << 8) - rhc_pkg::SN_W'(delta);
        b_item_next.sden = (a_max_reg == '0) ? CW'(1) : a_max_reg;
        b_item_next.hq    = '0;
        b_item_next.sq    = '0;
        b_item_next.value = a_max_reg;
    end

    logic               d_valid;
    logic               d_ready;
    logic               d_in_ready;
    rhc_pkg::div_item_t d_item;

    rhc_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (d_in_ready),
        .in_item   (b_item_reg),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item)
    );

    // Output stage: sector offset and wrap of negative red-sector hues.
    logic          o_valid_reg;
    logic [HW-1:0] o_hue_reg, o_hue_next;
    logic [CW-1:0] o_sat_reg, o_val_reg;
    logic [HW-1:0] hq_ext;

    assign hq_ext = HW'(d_item.hq);

    always_comb
    begin
        if (!d_item.neg || (hq_ext == '0))
        begin
            o_hue_next = d_item.offset + hq_ext;
        end
        else if (hq_ext <= d_item.offset)
        begin
            o_hue_next = d_item.offset - hq_ext;
        end
        else
        begin
            o_hue_next = d_item.offset + rhc_pkg::HUE_FULL_TURN - hq_ext;
        end
    end

    assign d_ready  = !o_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || d_in_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (d_ready)
            begin
                o_valid_reg <= d_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            a_red_reg   <= red;
            a_green_reg <= green;
            a_blue_reg  <= blue;
            a_max_reg   <= a_max_next;
            a_min_reg   <= a_min_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
        if (d_ready && d_valid)
        begin
            o_hue_reg <= o_hue_next;
            o_sat_reg <= d_item.sq;
            o_val_reg <= d_item.value;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {1'b0, o_val_reg, o_sat_reg, o_hue_reg};

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:0] < rhc_pkg::HUE_FULL_TURN))
        else $error("hue beyond a full turn");

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[30:23] == '0)) |-> (m_tdata[22:0] == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_grey_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[22:15] == '0)) |-> (m_tdata[14:0] == '0))
        else $error("zero saturation with nonzero hue");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[22:15] <= 8'd255) && (m_tdata[31] == 1'b0))
        else $error("padding bit of the result set");

endmodule

/* dv/tb_rgb_to_hsv_convert_core.sv */
`timescale 1ns / 100ps

module tb_rgb_to_hsv_convert_core;

    localparam int unsigned HUE_PER_SECTOR = 3840;
    localparam int          QUIET_LIMIT    = 1000;
    localparam int          DRAIN_CYCLES   = 30;

    typedef struct packed {
        logic [rhc_pkg::HUE_W-1:0] hue;
        logic [rhc_pkg::CH_W-1:0]  saturation;
        logic [rhc_pkg::CH_W-1:0]  brightness;
    } hsv_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red [7:0], green [15:8], blue [23:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // hue [14:0], saturation [22:15], brightness [30:23]

    hsv_t pending_hsv[$];
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    bit   full_rate      = 1'b0;

    rgb_to_hsv_convert_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned hsv_sector_hue(input int unsigned a, input int unsigned b,
                                                   input int unsigned d,
                                                   input int unsigned offset);
        int unsigned q;
        if (a >= b)
        begin
            q = (HUE_PER_SECTOR * (a - b)) / d;
            return offset + q;
        end
        q = (HUE_PER_SECTOR * (b - a)) / d;
        if (q == 0)
            return offset;
        if (q <= offset)
            return offset - q;
        return offset + int'(rhc_pkg::HUE_FULL_TURN) - q;
    endfunction

    function automatic hsv_t predict_hsv(input logic [rhc_pkg::CH_W-1:0] r,
                                         input logic [rhc_pkg::CH_W-1:0] g,
                                         input logic [rhc_pkg::CH_W-1:0] b);
        int unsigned ri;
        int unsigned gi;
        int unsigned bi;
        int unsigned top;
        int unsigned bottom;
        int unsigned delta;
        int unsigned hue;
        hsv_t        res;
        ri     = 32'(r);
        gi     = 32'(g);
        bi     = 32'(b);
        top    = ri;
        bottom = ri;
        if (gi > top)    top = gi;
        if (bi > top)    top = bi;
        if (gi < bottom) bottom = gi;
        if (bi < bottom) bottom = bi;
        delta = top - bottom;
        if (delta == 0)
            hue = 0;
        else if (top == ri)
            hue = hsv_sector_hue(gi, bi, delta, int'(rhc_pkg::RED_OFFSET));
        else if (top == gi)
            hue = hsv_sector_hue(bi, ri, delta, int'(rhc_pkg::GREEN_OFFSET));
        else
            hue = hsv_sector_hue(ri, gi, delta, int'(rhc_pkg::BLUE_OFFSET));
        res.hue        = hue[rhc_pkg::HUE_W-1:0];
        res.saturation = (top == 0) ? '0 : rhc_pkg::CH_W'((delta * 255) / top);
        res.brightness = top[rhc_pkg::CH_W-1:0];
        return res;
    endfunction

    task automatic send_pixel(input logic [rhc_pkg::CH_W-1:0] r,
                              input logic [rhc_pkg::CH_W-1:0] g,
                              input logic [rhc_pkg::CH_W-1:0] b);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {b, g, r};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_hsv.push_back(predict_hsv(r, g, b));
    endtask

    task automatic test_directed_pixels();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd200, 8'd10,  8'd150);
        send_pixel(8'd200, 8'd200, 8'd50);
        send_pixel(8'd50,  8'd200, 8'd200);
        send_pixel(8'd200, 8'd50,  8'd200);
        send_pixel(8'd100, 8'd200, 8'd50);
        send_pixel(8'd50,  8'd200, 8'd100);
        send_pixel(8'd10,  8'd20,  8'd200);
        send_pixel(8'd20,  8'd10,  8'd200);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd1);
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd0,   8'd1,   8'd0);
    endtask

    // Most pixels are uniform; the rest lean toward near-grey, dark, tied and
    // saturated colors so that every sector and the rounding edges get hit.
    task automatic test_random_pixels(input int count);
        logic [rhc_pkg::CH_W-1:0] r;
        logic [rhc_pkg::CH_W-1:0] g;
        logic [rhc_pkg::CH_W-1:0] b;
        int                       base;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                full_rate = ($urandom_range(0, 3) == 0);
            r = rhc_pkg::CH_W'($urandom_range(0, 255));
            g = rhc_pkg::CH_W'($urandom_range(0, 255));
            b = rhc_pkg::CH_W'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:
                begin
                    base = $urandom_range(0, 250);
                    r = rhc_pkg::CH_W'(base + $urandom_range(0, 5));
                    g = rhc_pkg::CH_W'(base + $urandom_range(0, 5));
                    b = rhc_pkg::CH_W'(base + $urandom_range(0, 5));
                end
                1:
                begin
                    r = rhc_pkg::CH_W'($urandom_range(0, 3));
                    g = rhc_pkg::CH_W'($urandom_range(0, 3));
                    b = rhc_pkg::CH_W'($urandom_range(0, 3));
                end
                2:
                begin
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                3:
                begin
                    case ($urandom_range(0, 2))
                        0: r = 8'd255;
                        1: g = 8'd255;
                        default: b = 8'd255;
                    endcase
                    case ($urandom_range(0, 2))
                        0: r = 8'd0;
                        1: g = 8'd0;
                        default: b = 8'd0;
                    endcase
                end
                default:
                begin
                end
            endcase
            send_pixel(r, g, b);
        end
        full_rate = 1'b0;
    endtask

    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = full_rate ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        hsv_t want;
        hsv_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hue        = m_tdata[14:0];
            got.saturation = m_tdata[22:15];
            got.brightness = m_tdata[30:23];
            if (pending_hsv.size() == 0)
            begin
                $display("%0t: unexpected result transfer, data %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_hsv.pop_front();
                if (got.hue !== want.hue)
                begin
                    $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
                    mismatch_count++;
                end
                if (got.saturation !== want.saturation)
                begin
                    $display("%0t: saturation expected %0d actual %0d", $time,
                             want.saturation, got.saturation);
                    mismatch_count++;
                end
                if (got.brightness !== want.brightness)
                begin
                    $display("%0t: brightness expected %0d actual %0d", $time,
                             want.brightness, got.brightness);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_pixels();
        test_random_pixels(600);
        test_drain_pause();
        test_random_pixels(700);
        test_drain_pause();
        test_random_pixels(650);

        s_tvalid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
